// ===== rtl/core/pi_controller_two_forms_macros.svh =====
// Assertion shorthands used by the controller sequencer (pictl_ctrl).
// Each macro expects clk and rst_n in the enclosing module.
`ifndef PI_CONTROLLER_TWO_FORMS_MACROS_SVH
`define PI_CONTROLLER_TWO_FORMS_MACROS_SVH

// Check a consequence in the same cycle as its trigger (or after a fixed delay
// written into the consequence itself).
`define PICTL_ASSERT_NOW(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> prop) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PICTL_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> prop) \
        else $error(msg);

`endif

// ===== rtl/core/pictl_pkg.sv =====
package pictl_pkg;

    // Default geometry
    localparam int DATA_WIDTH_DEF       = 16;
    localparam int GAIN_FRAC_BITS_DEF   = 8;
    localparam int INTEGRATOR_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int GAIN_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // Gain reset values
    localparam logic [GAIN_WIDTH-1:0] KP_RESET = 16'd256;
    localparam logic [GAIN_WIDTH-1:0] KI_RESET = 16'd0;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MODE    = 3'd0,
        REG_KP_GAIN = 3'd1,
        REG_KI_GAIN = 3'd2,
        REG_OUT_MIN = 3'd3,
        REG_OUT_MAX = 3'd4
    } cfg_reg_t;

    // Controller forms
    typedef enum logic {
        MODE_SERIES   = 1'b0,
        MODE_PARALLEL = 1'b1
    } pi_mode_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_COEF     = 3'd0,
        MUL_PREV_KP  = 3'd1,
        MUL_ERR_COEF = 3'd2,
        MUL_ERR_KP   = 3'd3,
        MUL_SUM_KI   = 3'd4
    } mul_sel_t;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD     = 2'd0,
        ACC_LOAD     = 2'd1,
        ACC_LOAD_NEG = 2'd2,
        ACC_ADD      = 2'd3
    } acc_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     sum_update;
        logic     coef_load;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     finalize;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        pi_mode_t mode;
    } dp_status_t;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/core/pictl_channels.sv =====
// Sample channel: setpoint and measurement
interface pictl_sample_if
    import pictl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

// Result channel: clamped drive and clamp flag
interface pictl_result_if
    import pictl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

// ===== rtl/core/pictl_dp.sv =====
module pictl_dp
    import pictl_pkg::*;
#(
    parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
    parameter int INTEGRATOR_WIDTH = INTEGRATOR_WIDTH_DEF
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]                    cfg_index,
    input  logic [max_i(DATA_WIDTH, GAIN_WIDTH)-1:0]      cfg_data,
    input  logic signed [DATA_WIDTH-1:0]                  setpoint,
    input  logic signed [DATA_WIDTH-1:0]                  measurement,
    input  dp_cmd_t                                       cmd,
    output dp_status_t                                    status,
    output logic signed [DATA_WIDTH-1:0]                  drive,
    output logic                                          clamped
);

    localparam int EW  = DATA_WIDTH + 1;
    localparam int KSW = max_i(GAIN_FRAC_BITS, GAIN_WIDTH) + 2;
    localparam int AW  = max_i(max_i(EW, INTEGRATOR_WIDTH), KSW);
    localparam int CW  = GAIN_WIDTH + max_i(GAIN_FRAC_BITS, GAIN_WIDTH) + 1 - GAIN_FRAC_BITS;
    localparam int BW  = max_i(CW, GAIN_WIDTH);
    localparam int PW  = AW + BW + 1;
    localparam int ACW = PW + 1;
    localparam int VW  = ACW + 1;
    localparam int SW  = max_i(INTEGRATOR_WIDTH, EW) + 1;

    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN_RST = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_RST = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [KSW-1:0]               ONE_Q       = KSW'(1) << GAIN_FRAC_BITS;

    // Configuration registers
    pi_mode_t                     mode_reg;
    logic [GAIN_WIDTH-1:0]        kp_reg;
    logic [GAIN_WIDTH-1:0]        ki_reg;
    logic signed [DATA_WIDTH-1:0] out_min_reg;
    logic signed [DATA_WIDTH-1:0] out_max_reg;

    // Controller state
    logic signed [DATA_WIDTH-1:0]       last_reg;
    logic signed [EW-1:0]               prev_err_reg;
    logic signed [INTEGRATOR_WIDTH-1:0] sum_reg;

    // Working registers
    logic signed [EW-1:0]         err_reg;
    logic signed [PW-1:0]         prod_reg;
    logic [CW-1:0]                coef_reg;
    logic signed [ACW-1:0]        acc_reg;
    logic signed [ACW-1:0]        acc_next;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         clamped_reg;

    logic [KSW-1:0]                     ksum;
    logic signed [AW-1:0]               mul_a;
    logic [BW-1:0]                      mul_b;
    logic signed [PW-1:0]               prod_next;
    logic signed [SW-1:0]               sum_wide;
    logic                               sum_ovf;
    logic signed [INTEGRATOR_WIDTH-1:0] sum_next;
    logic signed [ACW-1:0]              acc_shift;
    logic signed [VW-1:0]               value;
    logic signed [VW-1:0]               value_hi;
    logic                               over_max;
    logic                               under_min;
    logic signed [DATA_WIDTH-1:0]       drive_next;

    assign status.mode = mode_reg;
    assign drive       = drive_reg;
    assign clamped     = clamped_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SERIES;
            kp_reg      <= KP_RESET;
            ki_reg      <= KI_RESET;
            out_min_reg <= OUT_MIN_RST;
            out_max_reg <= OUT_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= pi_mode_t'(cfg_data[0]);
                REG_KP_GAIN: kp_reg      <= cfg_data[GAIN_WIDTH-1:0];
                REG_KI_GAIN: ki_reg      <= cfg_data[GAIN_WIDTH-1:0];
                REG_OUT_MIN: out_min_reg <= $signed(cfg_data[DATA_WIDTH-1:0]);
                REG_OUT_MAX: out_max_reg <= $signed(cfg_data[DATA_WIDTH-1:0]);
                default:     ;
            endcase
        end
    end

    // Select multiplier operands
    assign ksum = ONE_Q + KSW'(ki_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_COEF:
            begin
                mul_a = AW'($signed(ksum));
                mul_b = BW'(kp_reg);
            end
            MUL_PREV_KP:
            begin
                mul_a = AW'(prev_err_reg);
                mul_b = BW'(kp_reg);
            end
            MUL_ERR_COEF:
            begin
                mul_a = AW'(err_reg);
                mul_b = BW'(coef_reg);
            end
            MUL_ERR_KP:
            begin
                mul_a = AW'(err_reg);
                mul_b = BW'(kp_reg);
            end
            MUL_SUM_KI:
            begin
                mul_a = AW'(sum_reg);
                mul_b = BW'(ki_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared signed-by-unsigned multiplier
    assign prod_next = mul_a * $signed({1'b0, mul_b});

    // Accumulate products
    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_HOLD:     acc_next = acc_reg;
            ACC_LOAD:     acc_next = ACW'(prod_reg);
            ACC_LOAD_NEG: acc_next = -ACW'(prod_reg);
            ACC_ADD:      acc_next = acc_reg + ACW'(prod_reg);
            default:      acc_next = acc_reg;
        endcase
    end

    // Saturating integrator update
    assign sum_wide = SW'(sum_reg) + SW'(err_reg);
    assign sum_ovf  = !((&sum_wide[SW-1:INTEGRATOR_WIDTH-1]) ||
                        !(|sum_wide[SW-1:INTEGRATOR_WIDTH-1]));
    assign sum_next = sum_ovf ?
                      {sum_wide[SW-1], {(INTEGRATOR_WIDTH-1){~sum_wide[SW-1]}}} :
                      sum_wide[INTEGRATOR_WIDTH-1:0];

    // Scale, add the last output in series form, then clamp high and low
    assign acc_shift = acc_reg >>> GAIN_FRAC_BITS;
    assign value     = (mode_reg == MODE_SERIES) ? VW'(acc_shift) + VW'(last_reg)
                                                 : VW'(acc_shift);
    assign over_max  = value > VW'(out_max_reg);
    assign value_hi  = over_max ? VW'(out_max_reg) : value;
    assign under_min = value_hi < VW'(out_min_reg);

    always_comb
    begin
        priority if (under_min)
            drive_next = out_min_reg;
        else if (over_max)
            drive_next = out_max_reg;
        else
            drive_next = value[DATA_WIDTH-1:0];
    end

    // Controller state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cmd.sum_update)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.finalize)
            begin
                last_reg <= drive_next;
                if (mode_reg == MODE_SERIES)
                begin
                    prev_err_reg <= err_reg;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg <= EW'(setpoint) - EW'(measurement);
        end
        if (cmd.coef_load)
        begin
            coef_reg <= prod_reg[GAIN_FRAC_BITS +: CW];
        end
        if (cmd.finalize)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= over_max || under_min;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

// ===== rtl/core/pictl_ctrl.sv =====
`include "pi_controller_two_forms_macros.svh"

module pictl_ctrl
    import pictl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRE   = 6'b000010,
        S_MUL_A = 6'b000100,
        S_MUL_B = 6'b001000,
        S_ACC   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   parallel;

    assign parallel     = (status.mode == MODE_PARALLEL);
    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    // Sequence the shared multiplier and the accumulator
    always_comb
    begin
        state_next     = state_reg;
        cmd.load_in    = 1'b0;
        cmd.sum_update = 1'b0;
        cmd.coef_load  = 1'b0;
        cmd.mul_sel    = MUL_COEF;
        cmd.acc_op     = ACC_HOLD;
        cmd.finalize   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.sum_update = parallel;
                cmd.mul_sel    = parallel ? MUL_ERR_KP : MUL_COEF;
                state_next     = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.coef_load = !parallel;
                cmd.mul_sel   = parallel ? MUL_SUM_KI : MUL_PREV_KP;
                cmd.acc_op    = parallel ? ACC_LOAD : ACC_HOLD;
                state_next    = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_sel = MUL_ERR_COEF;
                cmd.acc_op  = parallel ? ACC_ADD : ACC_LOAD_NEG;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_op = parallel ? ACC_HOLD : ACC_ADD;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.finalize = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until it is taken
    always_comb
    begin
        priority if (cmd.finalize)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    `PICTL_ASSERT_NOW(a_fixed_latency, sample_valid && sample_ready, ##5 (state_reg == S_FIN), "item did not reach clamp stage in five cycles")
    `PICTL_ASSERT_NOW(a_no_overwrite, cmd.finalize, (!result_valid_reg || result_ready), "result overwritten before it was taken")
    `PICTL_ASSERT_NEXT(a_result_shown, cmd.finalize, result_valid_reg, "finished result not presented")

endmodule

// ===== rtl/core/pi_controller_two_forms.sv =====
// PI controller with two selectable forms. Each sample beat (setpoint,
// measurement) yields one result beat (drive, clamped). Mode 0 runs the series
// incremental form, drive = last + ((kp*(1+ki))*err - kp*prev_err) >> frac;
// mode 1 runs the parallel positional form, sum += err (saturating at
// INTEGRATOR_WIDTH), drive = (kp*err + ki*sum) >> frac. Shifts are arithmetic
// (round toward minus infinity). The value is clamped to out_max and then
// to out_min, so out_min wins when the limits cross; clamped flags either.
// Gains are unsigned with GAIN_FRAC_BITS fraction bits. The error is captured
// at the edge that accepts the sample beat; the states S_PRE, S_MUL_A and
// S_MUL_B then pass operands through the single shared multiplier, S_ACC
// finishes the series-form accumulation and S_FIN scales, clamps and
// registers the result. The sequencer returns to idle as the result is
// registered and takes no new sample before then. The result sits in an output
// register, so the next sample is accepted while it waits; only that sample's
// clamp step stalls while the earlier result is still not taken. Write
// configuration only while no sample is in flight.
module pi_controller_two_forms
    import pictl_pkg::*;
#(
    parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF,
    parameter int INTEGRATOR_WIDTH = INTEGRATOR_WIDTH_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]               cfg_index,
    input  logic [max_i(DATA_WIDTH, GAIN_WIDTH)-1:0] cfg_data,
    pictl_sample_if.sink                             sample,
    pictl_result_if.source                           result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    pictl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic and state
    pictl_dp #(
        .DATA_WIDTH       (DATA_WIDTH),
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
        .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .setpoint    (sample.setpoint),
        .measurement (sample.measurement),
        .cmd         (cmd),
        .status      (status),
        .drive       (result.drive),
        .clamped     (result.clamped)
    );

endmodule
